[hw/rtl/nccc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nccc_pkg
// Types, command codes and defaults for the nearest-centre confusion counter.
// ----------------------------------------------------------------------------
package nccc_pkg;

  localparam int NUM_CLASSES_DEF = 6;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 3;
  localparam int AXIS_W    = 12;
  localparam int CNT_OUT_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD     = 2'd0,
    CMD_CLASSIFY = 2'd1,
    CMD_READ     = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_ACC,
    ST_ROOT,
    ST_CMP,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [IDX_W-1:0]  center_index;
    logic [IDX_W-1:0]  true_class;
    logic [IDX_W-1:0]  read_row;
    logic [IDX_W-1:0]  read_col;
    logic [AXIS_W-1:0] axis_x;
    logic [AXIS_W-1:0] axis_y;
    logic [AXIS_W-1:0] axis_z;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]     winner_class;
    logic [CNT_OUT_W-1:0] cell_count;
    logic                 count_saturated;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic done;
  } root_ctrl_t;

endpackage

[hw/rtl/nccc_center_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nccc_center_mem
// Class centre store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nccc_center_mem #(
  parameter int NumClasses = 6,
  parameter int SampleBits = 12
) (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [$clog2(NumClasses)-1:0]   wr_addr_i,
  input  logic [3*SampleBits-1:0]         wr_data_i,
  input  logic [$clog2(NumClasses)-1:0]   rd_addr_i,
  output logic [3*SampleBits-1:0]         rd_data_o
);

  logic [3*SampleBits-1:0] mem_q [NumClasses];
  logic [3*SampleBits-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/nccc_count_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nccc_count_mem
// Confusion count store with per-entry valid bits; an invalid entry reads 0.
// ----------------------------------------------------------------------------
module nccc_count_mem #(
  parameter int NumClasses = 6,
  parameter int CountBits  = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        clr_i,
  input  logic                                        wr_en_i,
  input  logic [$clog2(NumClasses*NumClasses)-1:0]    addr_i,
  input  logic [CountBits-1:0]                        wr_data_i,
  output logic [CountBits-1:0]                        rd_data_o
);

  localparam int Depth = NumClasses * NumClasses;

  logic [CountBits-1:0] mem_q [Depth];
  logic [Depth-1:0]     vld_q;
  logic [CountBits-1:0] rd_data_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[addr_i];
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

[hw/rtl/nccc_root.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nccc_root
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module nccc_root #(
  parameter int SampleBits = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nccc_pkg::root_ctrl_t          ctrl_i,
  output nccc_pkg::root_ctrl_t          ctrl_o,
  input  logic [2*SampleBits+1:0]       radicand_i,
  output logic [SampleBits:0]           root_o
);

  import nccc_pkg::*;

  localparam int RootW = SampleBits + 1;
  localparam int RadW  = 2 * RootW;
  localparam int RemW  = RootW + 1;
  localparam int CntW  = $clog2(RootW + 1);

  logic [RadW-1:0]  rad_q, rad_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [RemW+1:0]  rem_sh;
  logic [RemW+1:0]  trial;
  logic             ge;

  assign rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial  = (RemW+2)'({root_q, 2'b01});
  assign ge     = rem_sh >= trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = rad_q << 2;
      rem_d  = ge ? RemW'(rem_sh - trial) : RemW'(rem_sh);
      root_d = {root_q[RootW-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(RootW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o       = root_q;
  assign ctrl_o.start = 1'b0;
  assign ctrl_o.done  = done_q;

endmodule

[hw/rtl/nearest_centroid_confusion_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_confusion_counter
// Nearest-centre classifier that tallies true/predicted class pairs in a
// confusion count matrix; loads centres, reads and clears the matrix.
//
//   channel  direction  valid        stall         payload
//   input    in         in_valid_i   in_stall_o    in_item_i  (in_item_t)
//   output   out        out_valid_o  out_stall_i   out_item_o (out_item_t)
//
// Load and clear go straight to the done state; read passes through ST_READ.
// Classify visits each centre in turn (fetch, square and accumulate per axis,
// root, compare), using the one-bit-per-cycle root unit and the single shared squarer.
// One item is in work at a time; the next is taken once its result has moved
// to the output register, which holds it while out_stall_i is high.
// Reset clears the count matrix at once through per-entry valid bits.
// ----------------------------------------------------------------------------
module nearest_centroid_confusion_counter #(
  parameter int NumClasses = nccc_pkg::NUM_CLASSES_DEF,
  parameter int SampleBits = nccc_pkg::SAMPLE_BITS_DEF,
  parameter int CountBits  = nccc_pkg::COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  nccc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nccc_pkg::out_item_t out_item_o
);

  import nccc_pkg::*;

  localparam int IdxW   = $clog2(NumClasses);
  localparam int CellAw = $clog2(NumClasses * NumClasses);
  localparam int SqW    = 2 * SampleBits;
  localparam int AccW   = SqW + 2;
  localparam int RootW  = SampleBits + 1;
  localparam logic [1:0] AxisLast = 2'd2;

  state_e                  state_q, state_d;
  logic [IDX_W-1:0]        tcls_q, tcls_d;
  logic [3*SampleBits-1:0] sample_q, sample_d;
  logic [IdxW-1:0]         c_q, c_d;
  logic [1:0]              axis_q, axis_d;
  logic [SqW-1:0]          sq_q, sq_d;
  logic [AccW-1:0]         acc_q, acc_d;
  logic [IdxW-1:0]         best_q, best_d;
  logic [RootW-1:0]        best_root_q, best_root_d;
  logic                    rd_ok_q, rd_ok_d;
  out_item_t               res_q, res_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_item_q, out_item_d;

  logic                    accept;
  logic                    out_free;
  logic                    out_load;
  logic [3*SampleBits-1:0] in_sample;
  logic [3*SampleBits-1:0] ctr_rd_data;
  logic                    ctr_wr_en;
  logic [SampleBits-1:0]   ctr_axis;
  logic [SampleBits-1:0]   smp_axis;
  logic [SampleBits-1:0]   diff;
  logic [CellAw-1:0]       cell_addr;
  logic                    cnt_wr_en;
  logic                    cnt_clr;
  logic [CountBits-1:0]    cnt_rd_data;
  logic [CountBits-1:0]    cnt_new;
  logic                    cnt_sat;
  logic                    tcls_ok;
  root_ctrl_t              root_req;
  root_ctrl_t              root_rsp;
  logic [RootW-1:0]        root_val;

  assign accept    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = (state_q == ST_DONE) && out_free;
  assign in_sample = {SampleBits'(in_item_i.axis_z), SampleBits'(in_item_i.axis_y),
                      SampleBits'(in_item_i.axis_x)};
  assign tcls_ok   = 32'(tcls_q) < NumClasses;

  assign ctr_axis = ctr_rd_data[axis_q*SampleBits +: SampleBits];
  assign smp_axis = sample_q[axis_q*SampleBits +: SampleBits];
  assign diff     = (smp_axis >= ctr_axis) ? (smp_axis - ctr_axis) : (ctr_axis - smp_axis);

  always_comb begin
    if (state_q == ST_IDLE) begin
      cell_addr = CellAw'(CellAw'(in_item_i.read_row) * CellAw'(NumClasses)
                          + CellAw'(in_item_i.read_col));
    end else begin
      cell_addr = CellAw'(CellAw'(tcls_q) * CellAw'(NumClasses) + CellAw'(best_q));
    end
  end

  assign cnt_sat = cnt_rd_data == {CountBits{1'b1}};
  assign cnt_new = cnt_sat ? cnt_rd_data : CountBits'(cnt_rd_data + 1'b1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_item_i.cmd)
            CMD_CLASSIFY: state_d = ST_FETCH;
            CMD_READ:     state_d = ST_READ;
            default:      state_d = ST_DONE;
          endcase
        end
      end
      ST_FETCH:   state_d = ST_MUL;
      ST_MUL:     state_d = ST_ACC;
      ST_ACC:     state_d = (axis_q == AxisLast) ? ST_ROOT : ST_MUL;
      ST_ROOT:    state_d = root_rsp.done ? ST_CMP : ST_ROOT;
      ST_CMP:     state_d = (c_q == IdxW'(NumClasses - 1)) ? ST_CELL_RD : ST_FETCH;
      ST_CELL_RD: state_d = tcls_ok ? ST_CELL_WR : ST_DONE;
      ST_CELL_WR: state_d = ST_DONE;
      ST_READ:    state_d = ST_DONE;
      ST_DONE:    state_d = out_free ? ST_IDLE : ST_DONE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and control
  always_comb begin
    tcls_d        = tcls_q;
    sample_d      = sample_q;
    c_d           = c_q;
    axis_d        = axis_q;
    sq_d          = sq_q;
    acc_d         = acc_q;
    best_d        = best_q;
    best_root_d   = best_root_q;
    rd_ok_d       = rd_ok_q;
    res_d         = res_q;
    ctr_wr_en     = 1'b0;
    cnt_wr_en     = 1'b0;
    cnt_clr       = 1'b0;
    root_req      = '0;
    out_valid_d   = out_valid_q && out_stall_i;
    out_item_d    = out_item_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d    = '0;
          tcls_d   = in_item_i.true_class;
          sample_d = in_sample;
          c_d      = '0;
          axis_d   = '0;
          acc_d    = '0;
          rd_ok_d  = (32'(in_item_i.read_row) < NumClasses) &&
                     (32'(in_item_i.read_col) < NumClasses);
          ctr_wr_en = (in_item_i.cmd == CMD_LOAD) &&
                      (32'(in_item_i.center_index) < NumClasses);
          cnt_clr   = in_item_i.cmd == CMD_CLEAR;
        end
      end
      ST_MUL: begin
        sq_d = SqW'(SqW'(diff) * SqW'(diff));
      end
      ST_ACC: begin
        acc_d  = AccW'(acc_q + AccW'(sq_q));
        axis_d = axis_q + 1'b1;
        root_req.start = axis_q == AxisLast;
      end
      ST_CMP: begin
        if (c_q == '0 || root_val < best_root_q) begin
          best_d      = c_q;
          best_root_d = root_val;
        end
        c_d    = c_q + 1'b1;
        axis_d = '0;
        acc_d  = '0;
      end
      ST_CELL_RD: begin
        res_d.winner_class = IDX_W'(best_q);
      end
      ST_CELL_WR: begin
        cnt_wr_en             = 1'b1;
        res_d.cell_count      = CNT_OUT_W'(cnt_new);
        res_d.count_saturated = cnt_sat;
      end
      ST_READ: begin
        res_d.cell_count = rd_ok_q ? CNT_OUT_W'(cnt_rd_data) : '0;
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_item_d  = res_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      c_q         <= '0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      c_q         <= c_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tcls_q      <= tcls_d;
    sample_q    <= sample_d;
    sq_q        <= sq_d;
    acc_q       <= acc_d;
    best_q      <= best_d;
    best_root_q <= best_root_d;
    rd_ok_q     <= rd_ok_d;
    res_q       <= res_d;
    out_item_q  <= out_item_d;
  end

  nccc_center_mem #(
    .NumClasses (NumClasses),
    .SampleBits (SampleBits)
  ) u_center_mem (
    .clk_i     (clk_i),
    .wr_en_i   (ctr_wr_en),
    .wr_addr_i (IdxW'(in_item_i.center_index)),
    .wr_data_i (in_sample),
    .rd_addr_i (c_q),
    .rd_data_o (ctr_rd_data)
  );

  nccc_count_mem #(
    .NumClasses (NumClasses),
    .CountBits  (CountBits)
  ) u_count_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (cnt_clr),
    .wr_en_i   (cnt_wr_en),
    .addr_i    (cell_addr),
    .wr_data_i (cnt_new),
    .rd_data_o (cnt_rd_data)
  );

  nccc_root #(
    .SampleBits (SampleBits)
  ) u_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (root_req),
    .ctrl_o     (root_rsp),
    .radicand_i (acc_d),
    .root_o     (root_val)
  );

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_root_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_rsp.done |-> state_q == ST_ROOT)
    else $error("root result arrived outside the wait state");

  a_cell_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_wr_en |-> (32'(tcls_q) < NumClasses) && (32'(best_q) < NumClasses))
    else $error("count write outside the matrix");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("result lost on the way to the output register");

  a_sat_means_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.count_saturated
      |-> out_item_o.cell_count == CNT_OUT_W'({CountBits{1'b1}}))
    else $error("saturation flagged below the maximum count");

endmodule
